FILE: src/nfsa_pkg.sv
`default_nettype none

package nfsa_pkg;

  // fixed field widths
  localparam int unsigned IDX_BITS = 8;
  localparam int unsigned CAP_BITS = 16;
  localparam int unsigned OCC_BITS = 16;
  localparam int unsigned CFG_BITS = 9;
  // wide enough to hold any table depth, inclusive
  localparam int unsigned CNT_BITS = 13;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RDWAIT,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // control from the sequencer into the scan unit
  typedef struct packed {
    logic start;
    logic rd_valid;
  } scan_ctrl_t;

  // status from the scan unit
  typedef struct packed {
    logic have;
    logic busy;
  } scan_stat_t;

endpackage

`default_nettype wire

FILE: src/nearest_free_slot_allocator.sv
`default_nettype none

// Nearest free slot allocator. The site table (x, y, capacity, occupancy) lives in one
// synchronous RAM of MAX_SITES words. After reset a clearing pass writes every entry, one a
// cycle, and no item is accepted until that pass is done; configuration writes are taken
// throughout. A load writes its entry directly, a read fetches one word, and a place
// request scans the first n entries, where n is sites_in_use clipped to MAX_SITES: the
// scan reads one RAM word per cycle through a two-stage distance and compare pipeline,
// then writes the updated occupancy back. A finished result waits in the output register
// while the next item is accepted.
module nearest_free_slot_allocator #(
  parameter int unsigned MAX_SITES  = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [nfsa_pkg::CFG_BITS-1:0] cfg_data_i,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [1:0]                   opcode_i,
  input  wire logic        [nfsa_pkg::IDX_BITS-1:0] site_index_i,
  input  wire logic signed [15:0]                  pos_x_i,
  input  wire logic signed [15:0]                  pos_y_i,
  input  wire logic        [nfsa_pkg::CAP_BITS-1:0] capacity_i,
  // results
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [nfsa_pkg::IDX_BITS-1:0] chosen_index_o,
  output logic             [nfsa_pkg::OCC_BITS-1:0] occupancy_o,
  output logic                                     found_o
);

  import nfsa_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_SITES);
  localparam int unsigned NW     = AW + 1;
  localparam int unsigned WW     = 2 * COORD_BITS + CAP_BITS + OCC_BITS;
  localparam int unsigned CAP_LO = OCC_BITS;
  localparam int unsigned Y_LO   = OCC_BITS + CAP_BITS;
  localparam int unsigned X_LO   = Y_LO + COORD_BITS;

  state_e state_q, state_d;

  logic [CFG_BITS-1:0] sites_q;
  logic [AW-1:0]       addr_q, addr_d;
  logic [NW-1:0]       n_q, n_d;
  logic                rd_valid_q, rd_valid_d;
  logic [AW-1:0]       rd_idx_q;

  logic signed [COORD_BITS-1:0] req_x_q, req_y_q;

  logic [IDX_BITS-1:0] res_idx_q, res_idx_d;
  logic [OCC_BITS-1:0] res_occ_q, res_occ_d;
  logic                res_found_q, res_found_d;

  logic out_valid_q, out_valid_d;
  logic out_load;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  logic signed [COORD_BITS-1:0] rd_x, rd_y, in_x, in_y;
  logic [CAP_BITS-1:0] rd_cap;
  logic [OCC_BITS-1:0] rd_occ;
  logic [31:0]         in_x_ext, in_y_ext;
  logic [CNT_BITS-1:0] idx_ext, cfg_ext, n_ext, best_ext;
  logic [AW-1:0]       in_addr;
  logic                in_range, in_xfer, last;
  logic [OCC_BITS-1:0] occ_inc;

  scan_ctrl_t scan_ctrl;
  scan_stat_t scan_stat;
  logic [AW-1:0]                best_idx;
  logic signed [COORD_BITS-1:0] best_x, best_y;
  logic [CAP_BITS-1:0]          best_cap;
  logic [OCC_BITS-1:0]          best_occ;

  // input field decoding
  assign in_x_ext = {16'b0, pos_x_i};
  assign in_y_ext = {16'b0, pos_y_i};
  assign in_x     = in_x_ext[COORD_BITS-1:0];
  assign in_y     = in_y_ext[COORD_BITS-1:0];
  assign idx_ext  = CNT_BITS'(site_index_i);
  assign in_range = idx_ext < CNT_BITS'(MAX_SITES);
  assign in_addr  = idx_ext[AW-1:0];
  assign cfg_ext  = CNT_BITS'(sites_q);
  assign n_ext    = (cfg_ext > CNT_BITS'(MAX_SITES)) ? CNT_BITS'(MAX_SITES) : cfg_ext;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign last     = {1'b0, addr_q} == (n_q - 1'b1);

  // memory word fields
  assign rd_x   = mem_rdata[X_LO +: COORD_BITS];
  assign rd_y   = mem_rdata[Y_LO +: COORD_BITS];
  assign rd_cap = mem_rdata[CAP_LO +: CAP_BITS];
  assign rd_occ = mem_rdata[OCC_BITS-1:0];

  assign occ_inc  = best_occ + 1'b1;
  assign best_ext = CNT_BITS'(best_idx);

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // sequencer and memory port control
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    n_d         = n_q;
    rd_valid_d  = 1'b0;
    res_idx_d   = res_idx_q;
    res_occ_d   = res_occ_q;
    res_found_d = res_found_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    scan_ctrl.start    = 1'b0;
    scan_ctrl.rd_valid = rd_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_q == AW'(MAX_SITES - 1)) begin
          state_d = ST_IDLE;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          res_idx_d   = '0;
          res_occ_d   = '0;
          res_found_d = 1'b0;
          state_d     = ST_RESP;
          unique case (opcode_i)
            OP_LOAD: begin
              if (in_range) begin
                mem_we      = 1'b1;
                mem_waddr   = in_addr;
                mem_wdata   = {in_x, in_y, capacity_i, {OCC_BITS{1'b0}}};
                res_idx_d   = site_index_i;
                res_found_d = 1'b1;
              end
            end
            OP_PLACE: begin
              scan_ctrl.start = 1'b1;
              addr_d          = '0;
              n_d             = n_ext[NW-1:0];
              if (n_ext != '0) begin
                state_d = ST_SCAN;
              end
            end
            OP_READ: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = in_addr;
                res_idx_d = site_index_i;
                state_d   = ST_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_re     = 1'b1;
        rd_valid_d = 1'b1;
        if (last) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !scan_stat.busy) begin
          state_d = ST_UPDATE;
        end
      end
      ST_RDWAIT: begin
        res_occ_d   = rd_occ;
        res_found_d = 1'b1;
        state_d     = ST_RESP;
      end
      ST_UPDATE: begin
        if (scan_stat.have) begin
          mem_we      = 1'b1;
          mem_waddr   = best_idx;
          mem_wdata   = {best_x, best_y, best_cap, occ_inc};
          res_idx_d   = best_ext[IDX_BITS-1:0];
          res_occ_d   = occ_inc;
          res_found_d = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sites_q     <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        sites_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    rd_idx_q    <= addr_q;
    res_idx_q   <= res_idx_d;
    res_occ_q   <= res_occ_d;
    res_found_q <= res_found_d;
    if (in_xfer) begin
      req_x_q <= in_x;
      req_y_q <= in_y;
    end
    if (out_load) begin
      chosen_index_o <= res_idx_q;
      occupancy_o    <= res_occ_q;
      found_o        <= res_found_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // site table
  nfsa_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_SITES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // distance and best-candidate pipeline
  nfsa_scan #(
    .ADDR_BITS  (AW),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .rd_idx_i   (rd_idx_q),
    .rd_x_i     (rd_x),
    .rd_y_i     (rd_y),
    .rd_cap_i   (rd_cap),
    .rd_occ_i   (rd_occ),
    .req_x_i    (req_x_q),
    .req_y_i    (req_y_q),
    .stat_o     (scan_stat),
    .best_idx_o (best_idx),
    .best_x_o   (best_x),
    .best_y_o   (best_y),
    .best_cap_o (best_cap),
    .best_occ_o (best_occ)
  );

`ifndef SYNTHESIS
  // no table write while scan reads are in flight
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q || scan_stat.busy) |-> !mem_we)
    else $error("table write during scan");

  // write-back only after the compare pipeline has drained
  a_update_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (!rd_valid_q && !scan_stat.busy))
    else $error("update before scan drained");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("second item accepted back to back");
`endif

endmodule

`default_nettype wire

FILE: src/nfsa_ram.sv
`default_nettype none

module nfsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/nfsa_scan.sv
`default_nettype none

module nfsa_scan #(
  parameter int unsigned ADDR_BITS  = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire nfsa_pkg::scan_ctrl_t                ctrl_i,
  input  wire logic        [ADDR_BITS-1:0]         rd_idx_i,
  input  wire logic signed [COORD_BITS-1:0]        rd_x_i,
  input  wire logic signed [COORD_BITS-1:0]        rd_y_i,
  input  wire logic        [nfsa_pkg::CAP_BITS-1:0] rd_cap_i,
  input  wire logic        [nfsa_pkg::OCC_BITS-1:0] rd_occ_i,
  input  wire logic signed [COORD_BITS-1:0]        req_x_i,
  input  wire logic signed [COORD_BITS-1:0]        req_y_i,
  output nfsa_pkg::scan_stat_t                     stat_o,
  output logic             [ADDR_BITS-1:0]         best_idx_o,
  output logic signed      [COORD_BITS-1:0]        best_x_o,
  output logic signed      [COORD_BITS-1:0]        best_y_o,
  output logic             [nfsa_pkg::CAP_BITS-1:0] best_cap_o,
  output logic             [nfsa_pkg::OCC_BITS-1:0] best_occ_o
);

  import nfsa_pkg::*;

  localparam int unsigned DW = COORD_BITS + 2;

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] adx, ady;
  logic        [DW-1:0]       mdist;

  // stage 1 registers
  logic                         s1_valid_q;
  logic                         s1_free_q;
  logic        [DW-1:0]         s1_d_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic        [CAP_BITS-1:0]   s1_cap_q;
  logic        [OCC_BITS-1:0]   s1_occ_q;
  logic        [ADDR_BITS-1:0]  s1_idx_q;

  // best candidate
  logic                         have_q;
  logic        [DW-1:0]         best_d_q;
  logic                         better;

  // manhattan distance of the entry just read
  assign dx    = {req_x_i[COORD_BITS-1], req_x_i} - {rd_x_i[COORD_BITS-1], rd_x_i};
  assign dy    = {req_y_i[COORD_BITS-1], req_y_i} - {rd_y_i[COORD_BITS-1], rd_y_i};
  assign adx   = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign ady   = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign mdist = {1'b0, adx} + {1'b0, ady};

  // stage 1 valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.rd_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_valid) begin
      s1_free_q <= rd_occ_i < rd_cap_i;
      s1_d_q    <= mdist;
      s1_x_q    <= rd_x_i;
      s1_y_q    <= rd_y_i;
      s1_cap_q  <= rd_cap_i;
      s1_occ_q  <= rd_occ_i;
      s1_idx_q  <= rd_idx_i;
    end
  end

  // ordering: distance, then x, then y; lower index wins by scan order
  assign better = !have_q || (s1_d_q < best_d_q) ||
                  ((s1_d_q == best_d_q) &&
                   ((s1_x_q < best_x_o) || ((s1_x_q == best_x_o) && (s1_y_q < best_y_o))));

  // stage 2 found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (ctrl_i.start) begin
      have_q <= 1'b0;
    end else if (s1_valid_q && s1_free_q) begin
      have_q <= 1'b1;
    end
  end

  // stage 2 best entry
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_free_q && better && !ctrl_i.start) begin
      best_d_q   <= s1_d_q;
      best_x_o   <= s1_x_q;
      best_y_o   <= s1_y_q;
      best_cap_o <= s1_cap_q;
      best_occ_o <= s1_occ_q;
      best_idx_o <= s1_idx_q;
    end
  end

  assign stat_o.have = have_q;
  assign stat_o.busy = s1_valid_q;

endmodule

`default_nettype wire
